// ===== design/gsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the gas sensor ppm estimator
// Register indexes, reset values and the request type between the front and
// the back of the block.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int unsigned CalSamplesDef  = 50;
  localparam int unsigned MeasSamplesDef = 5;
  localparam int unsigned CntW           = 6;
  localparam int unsigned SumW           = 38;
  localparam int unsigned NumRegs        = 8;
  localparam int unsigned RegIdxW        = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegLoadRes    = 3'd0,
    RegCleanAir   = 3'd1,
    RegLpgLogPpm  = 3'd2,
    RegLpgLogRat  = 3'd3,
    RegLpgSlope   = 3'd4,
    RegSmkLogPpm  = 3'd5,
    RegSmkLogRat  = 3'd6,
    RegSmkSlope   = 3'd7
  } reg_idx_e;

  localparam logic [15:0] LoadResRst   = 16'd1280;
  localparam logic [15:0] CleanAirRst  = 16'd2516;
  localparam logic [15:0] LpgLogPpmRst = 16'd9421;
  localparam logic [15:0] LpgLogRatRst = 16'd860;
  localparam logic [15:0] LpgSlopeRst  = 16'hF87B;
  localparam logic [15:0] SmkLogPpmRst = 16'd9421;
  localparam logic [15:0] SmkLogRatRst = 16'd2171;
  localparam logic [15:0] SmkSlopeRst  = 16'hF8F6;

  localparam logic [9:0] AdcFull = 10'd1023;

  // One request from the front (a sample to convert) to the back.
  typedef struct packed {
    logic       cmd;
    logic [9:0] adc;
  } gsp_req_t;

endpackage

// ===== design/gsp_divider.sv =====
// ----------------------------------------------------------------------------
// gsp_divider: shared restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsp_divider
  import gsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;

  assign trial = {rem_q, quot_q[63]} - {2'b00, den_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d  = trial[32:0];
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = {rem_q[31:0], quot_q[63]};
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/gsp_front.sv =====
// ----------------------------------------------------------------------------
// gsp_front: sample intake
// Two-entry request queue between the input ports and the back end.
// ----------------------------------------------------------------------------
module gsp_front
  import gsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  gsp_req_t req_i,
  output logic     req_valid_o,
  output gsp_req_t req_o,
  input  logic     req_take_i
);

  gsp_req_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full        = (cnt_q == 2'd2);
  assign wr          = push && !full;
  assign req_valid_o = (cnt_q != 2'd0);
  assign rd          = req_take_i && req_valid_o;
  assign req_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !wr) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !rd) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ===== design/gsp_back.sv =====
// ----------------------------------------------------------------------------
// gsp_back: conversion, averaging and curve evaluation
// Sequencer around one shared divider; log and exponent are evaluated step by
// step with a single shared 33x33 multiplier.
// ----------------------------------------------------------------------------
module gsp_back
  import gsp_pkg::*;
#(
  parameter int unsigned CalSamples  = CalSamplesDef,
  parameter int unsigned MeasSamples = MeasSamplesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  gsp_req_t    req_i,
  output logic        req_take_o,
  input  logic [15:0] cfg_q_i [NumRegs],
  output logic        res_valid_o,
  input  logic        res_take_i,
  output logic        kind_o,
  output logic [31:0] ref_o,
  output logic [14:0] lpg_o,
  output logic [14:0] smoke_o,
  output logic        fault_o
);

  typedef enum logic [4:0] {
    StIdle, StRsDiv, StRsWait, StAcc, StAvgWait, StRefWait, StRatWait,
    StLogNorm, StLogSq, StLogSq2, StLog10, StCrvPrep, StCrvDiv, StCrvWait, StExpMul,
    StExpMul2, StExpRoot, StExpRootW, StExpAcc, StExpAccW, StExpFin, StOut
  } state_e;

  localparam logic [CntW-1:0] CalCnt  = CntW'(CalSamples);
  localparam logic [CntW-1:0] MeasCnt = CntW'(MeasSamples);

  state_e          st_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q;
  logic            mode_q, rfault_q, flt_q;
  logic [31:0]     ref_q;
  logic [9:0]      adc_q;
  logic [63:0]     m_q;
  logic [4:0]      p_q;
  logic [4:0]      it_q;
  logic [15:0]     frac_q;
  logic signed [31:0] lr_q;
  logic            crv_q;
  logic signed [47:0] dnum_q;
  logic            dneg_q;
  logic signed [31:0] e_q;
  logic [47:0]     t_q;
  logic [63:0]     root_q, acc_q;
  logic [14:0]     lpg_q, smk_q, ppm_tmp;
  logic            out_v_q;
  logic            kind_out_q, flt_out_q;
  logic [31:0]     ref_out_q;
  logic [14:0]     lpg_out_q, smk_out_q;

  // divider
  logic        div_start;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [63:0] div_quot;

  gsp_divider u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // integer square root uses the divider-free digit loop below
  logic [63:0] sq_x_q, sq_r_q, sq_bit_q;

  logic [15:0] sel_p, sel_r, sel_s;
  always_comb begin
    sel_p = crv_q ? cfg_q_i[RegSmkLogPpm] : cfg_q_i[RegLpgLogPpm];
    sel_r = crv_q ? cfg_q_i[RegSmkLogRat] : cfg_q_i[RegLpgLogRat];
    sel_s = crv_q ? cfg_q_i[RegSmkSlope]  : cfg_q_i[RegLpgSlope];
  end

  logic [31:0] ratio_w;
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  assign mul_p = 66'(mul_a) * 66'(mul_b);

  logic [4:0]  lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (m_q[i]) lead = 5'(i);
    end
  end

  logic [CntW-1:0] tgt;
  assign tgt = mode_q ? MeasCnt : CalCnt;

  always_comb begin
    mul_a = m_q[32:0];
    mul_b = m_q[32:0];
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    ratio_w = (div_quot[63:32] != 0) ? 32'hFFFFFFFF : div_quot[31:0];
    unique case (st_q)
      StRsDiv: begin
        div_start = 1'b1;
        div_num = 64'({32'(cfg_q_i[RegLoadRes]) * 32'(AdcFull - adc_q), 8'd0});
        div_den = 32'(adc_q);
      end
      StAcc: begin
        div_start = 1'b1;
        div_num = 64'(sum_q);
        div_den = 32'(cnt_q);
      end
      StExpAcc: begin
        mul_a = acc_q[32:0];
        mul_b = root_q[32:0];
      end
      default: ;
    endcase
    if (st_q == StAvgWait && div_done) begin
      div_start = 1'b1;
      if (!mode_q) begin
        div_num = {div_quot[55:0], 8'd0};
        div_den = 32'(cfg_q_i[RegCleanAir]);
      end else begin
        div_num = {div_quot[47:0], 16'd0};
        div_den = ref_q;
      end
    end
    if (st_q == StCrvDiv) begin
      div_start = 1'b1;
      div_num = 64'(dneg_q ? -dnum_q : dnum_q);
      div_den = 32'($signed(sel_s) < 0 ? -$signed(sel_s) : $signed(sel_s));
    end
    if (st_q == StExpMul) begin
      mul_a = 33'(e_q[31] ? -e_q : e_q);
      mul_b = 33'd217706;
    end
  end

  logic [63:0] sat_acc;
  always_comb begin
    sat_acc = (acc_q << t_q[31:28]) >> 30;
    ppm_tmp = (sat_acc > 64'd32767) ? 15'h7FFF : sat_acc[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      sum_q      <= '0;
      cnt_q      <= '0;
      mode_q     <= 1'b0;
      rfault_q   <= 1'b0;
      ref_q      <= '0;
      out_v_q    <= 1'b0;
      flt_q      <= 1'b0;
      kind_out_q <= 1'b0;
      flt_out_q  <= 1'b0;
      ref_out_q  <= '0;
      lpg_out_q  <= '0;
      smk_out_q  <= '0;
    end else begin
      if (res_take_i && out_v_q) out_v_q <= 1'b0;
      unique case (st_q)
        StIdle: if (req_valid_i) begin
          adc_q <= req_i.adc;
          if (cnt_q != 0 && req_i.cmd != mode_q) begin
            sum_q <= '0; cnt_q <= '0; rfault_q <= 1'b0;
          end
          mode_q <= req_i.cmd;
          st_q   <= StRsDiv;
        end
        StRsDiv: st_q <= StRsWait;
        StRsWait: if (div_done || adc_q == 0) begin
          if (adc_q == 0) begin
            rfault_q <= 1'b1;
            sum_q <= sum_q + SumW'(32'hFFFFFFFF);
          end else begin
            sum_q <= sum_q + SumW'((div_quot[63:32] != 0) ? 32'hFFFFFFFF : div_quot[31:0]);
          end
          cnt_q <= cnt_q + 1'b1;
          st_q  <= (cnt_q + 1'b1 < tgt) ? StIdle : StAcc;
        end
        StAcc: begin
          flt_q <= rfault_q;
          st_q  <= StAvgWait;
        end
        StAvgWait: if (div_done) begin
          st_q  <= mode_q ? StRatWait : StRefWait;
        end
        StRefWait: if (div_done) begin
          if (cfg_q_i[RegCleanAir] == 0) begin
            ref_q <= 32'hFFFFFFFF; flt_q <= 1'b1;
          end else begin
            ref_q <= ratio_w;
          end
          lpg_q <= '0; smk_q <= '0;
          st_q  <= StOut;
        end
        StRatWait: if (div_done) begin
          if (ref_q == 0) begin
            m_q <= 64'hFFFFFFFF; flt_q <= 1'b1;
          end else begin
            m_q <= (ratio_w == 0) ? 64'd1 : 64'(ratio_w);
          end
          st_q <= StLogNorm;
        end
        StLogNorm: begin
          p_q    <= lead;
          m_q    <= m_q << (5'd31 - lead);
          it_q   <= '0;
          frac_q <= '0;
          st_q   <= StLogSq;
        end
        StLogSq: begin
          m_q  <= 64'(mul_p >> 31);
          st_q <= StLogSq2;
        end
        StLogSq2: begin
          if (m_q[32]) begin
            m_q <= m_q >> 1;
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            frac_q <= {frac_q[14:0], 1'b0};
          end
          it_q <= it_q + 1'b1;
          st_q <= (it_q == 5'd15) ? StLog10 : StLogSq;
        end
        StLog10: begin
          lr_q <= 32'((($signed({1'b0, p_q}) - 6'sd16) * 64'sd65536
                  + $signed({1'b0, frac_q})) * 64'sd19728 + 64'sd524288 >>> 20);
          crv_q <= 1'b0;
          st_q  <= StCrvPrep;
        end
        // let the numerator register pick up the current curve
        StCrvPrep: st_q <= StCrvDiv;
        StCrvDiv: begin
          st_q <= StCrvWait;
        end
        StCrvWait: if (sel_s == 0 || div_done) begin
          if (sel_s == 0) begin
            flt_q <= 1'b1;
            if (crv_q) smk_q <= 15'h7FFF; else lpg_q <= 15'h7FFF;
            if (crv_q) st_q <= StOut;
            else begin crv_q <= 1'b1; st_q <= StCrvPrep; end
          end else begin
            e_q <= ((dneg_q ^ sel_s[15]) ? -$signed(div_quot[31:0])
                   : $signed(div_quot[31:0])) + 32'($signed(sel_p));
            st_q <= StExpMul;
          end
        end
        StExpMul: begin
          t_q  <= mul_p[47:0];
          st_q <= StExpMul2;
        end
        StExpMul2: begin
          if (e_q[31] && t_q != 0) begin
            if (crv_q) smk_q <= '0; else lpg_q <= '0;
            st_q <= StExpFin;
          end else if (t_q >= (48'd15 << 28)) begin
            if (crv_q) smk_q <= 15'h7FFF; else lpg_q <= 15'h7FFF;
            st_q <= StExpFin;
          end else begin
            root_q <= 64'd1 << 31;
            acc_q  <= 64'd1 << 30;
            it_q   <= '0;
            st_q   <= StExpRoot;
          end
        end
        StExpRoot: begin
          sq_x_q   <= root_q << 30;
          sq_r_q   <= '0;
          sq_bit_q <= 64'd1 << 62;
          st_q     <= StExpRootW;
        end
        StExpRootW: begin
          if (sq_bit_q == 0) begin
            root_q <= sq_r_q;
            st_q   <= t_q[27 - it_q] ? StExpAcc : StExpAccW;
          end else if (sq_bit_q > sq_x_q && sq_r_q == 0) begin
            sq_bit_q <= sq_bit_q >> 2;
          end else if (sq_x_q >= sq_r_q + sq_bit_q) begin
            sq_x_q   <= sq_x_q - (sq_r_q + sq_bit_q);
            sq_r_q   <= (sq_r_q >> 1) + sq_bit_q;
            sq_bit_q <= sq_bit_q >> 2;
          end else begin
            sq_r_q   <= sq_r_q >> 1;
            sq_bit_q <= sq_bit_q >> 2;
          end
        end
        StExpAcc: begin
          acc_q <= 64'(mul_p >> 30);
          st_q  <= StExpAccW;
        end
        StExpAccW: begin
          it_q <= it_q + 1'b1;
          if (it_q == 5'd15) begin
            if (crv_q) smk_q <= ppm_tmp; else lpg_q <= ppm_tmp;
            st_q <= StExpFin;
          end else begin
            st_q <= StExpRoot;
          end
        end
        StExpFin: begin
          if (crv_q) st_q <= StOut;
          else begin crv_q <= 1'b1; st_q <= StCrvPrep; end
        end
        // hand the result to the output register once it is free
        StOut: if (!out_v_q) begin
          out_v_q    <= 1'b1;
          kind_out_q <= mode_q;
          ref_out_q  <= ref_q;
          lpg_out_q  <= lpg_q;
          smk_out_q  <= smk_q;
          flt_out_q  <= flt_q;
          sum_q      <= '0;
          cnt_q      <= '0;
          rfault_q   <= 1'b0;
          st_q       <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // signed curve numerator, registered in the cycle before the divide
  always_ff @(posedge clk_i) begin
    dnum_q <= 48'((lr_q - 32'($signed(sel_r))) * 4096);
    dneg_q <= (lr_q - 32'($signed(sel_r))) < 0;
  end

  assign req_take_o  = (st_q == StIdle);
  assign res_valid_o = out_v_q;
  assign kind_o      = kind_out_q;
  assign ref_o       = ref_out_q;
  assign lpg_o       = lpg_out_q;
  assign smoke_o     = smk_out_q;
  assign fault_o     = flt_out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle) |-> (cnt_q < tgt || cnt_q == 0)) else $error("count past target");
  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut && !out_v_q) |=> (cnt_q == 0 && out_v_q)) else $error("run not cleared");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take_o |-> st_q == StIdle) else $error("take outside idle");
`endif

endmodule

// ===== design/gas_sensor_ppm_estimator.sv =====
// Per sample the back end runs one divide on the shared divider for Rs; the
// sample that ends a run adds two divides for calibration, and for measurement
// two divides, 16 log squarings, then one divide and 16 square roots per curve.
// The back end takes a new sample only when idle; a result register frees it.
// Reset clears run state and reference, and loads register defaults.
// ----------------------------------------------------------------------------
// gas_sensor_ppm_estimator: MQ-style gas sensor ppm estimator
// Intake queue, back-end sequencer and configuration registers.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_estimator
  import gsp_pkg::*;
#(
  parameter int unsigned CalSamples  = CalSamplesDef,
  parameter int unsigned MeasSamples = MeasSamplesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               cmd_i,
  input  logic [9:0]         adc_sample_i,
  output logic               empty,
  input  logic               pop,
  output logic               kind_o,
  output logic [31:0]        ref_resistance_out_o,
  output logic [14:0]        lpg_ppm_o,
  output logic [14:0]        smoke_ppm_o,
  output logic               fault_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0] cfg_q [NumRegs];
  gsp_req_t    in_req, q_req;
  logic        q_valid, q_take, res_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[RegLoadRes]   <= LoadResRst;
      cfg_q[RegCleanAir]  <= CleanAirRst;
      cfg_q[RegLpgLogPpm] <= LpgLogPpmRst;
      cfg_q[RegLpgLogRat] <= LpgLogRatRst;
      cfg_q[RegLpgSlope]  <= LpgSlopeRst;
      cfg_q[RegSmkLogPpm] <= SmkLogPpmRst;
      cfg_q[RegSmkLogRat] <= SmkLogRatRst;
      cfg_q[RegSmkSlope]  <= SmkSlopeRst;
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign in_req.cmd = cmd_i;
  assign in_req.adc = adc_sample_i;

  gsp_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .req_i       (in_req),
    .req_valid_o (q_valid),
    .req_o       (q_req),
    .req_take_i  (q_take)
  );

  gsp_back #(.CalSamples(CalSamples), .MeasSamples(MeasSamples)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i (q_valid),
    .req_i       (q_req),
    .req_take_o  (q_take),
    .cfg_q_i     (cfg_q),
    .res_valid_o (res_valid),
    .res_take_i  (pop),
    .kind_o,
    .ref_o       (ref_resistance_out_o),
    .lpg_o       (lpg_ppm_o),
    .smoke_o     (smoke_ppm_o),
    .fault_o
  );

  assign empty = !res_valid;

endmodule
